// ----- design/drlc_pkg.sv -----
// Package for the debounced running light controller.
// Holds shared constants, codes, the key-event and result structs and the period table.
// No dependencies.
package drlc_pkg;

  localparam int KEY_NUMBER = 4;
  localparam int DEF_LED_RING_SIZE = 4;
  localparam int DEF_SPEED_STEPS = 8;
  localparam int CLK_HZ = 50_000_000;
  localparam int PERIOD_TABLE_LEN = 8;

  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W = 4;
  localparam int DEBOUNCE_W = 4;
  localparam int DEF_SPEED_W = 3;
  localparam int PERIOD_W = 28;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_HOLD_POLLS = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_DEFAULT_SPEED = 1'b1;

  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 4'd4;
  localparam logic [DEF_SPEED_W-1:0] DEFAULT_SPEED_RESET = 3'd4;

  // request kinds
  localparam logic REQ_STEP = 1'b0;
  localparam logic REQ_POLL = 1'b1;

  // key roles, by key number
  localparam int KEY_SPEED_UP = 0;
  localparam int KEY_SPEED_DOWN = 1;
  localparam int KEY_RUN = 2;
  localparam int KEY_RESTORE = 3;

  typedef struct packed {
    logic faster;
    logic slower;
    logic toggle_run;
    logic restore;
  } drlc_keys_t;

  typedef struct packed {
    logic [3:0]          led_pattern;
    logic [2:0]          speed_level;
    logic [PERIOD_W-1:0] step_period;
    logic                restart_timer;
    logic                is_running;
  } drlc_result_t;

  function automatic logic [PERIOD_W-1:0] period_of(input logic [2:0] idx);
    logic [PERIOD_W-1:0] p;
    case (idx)
      3'd0:    p = PERIOD_W'(CLK_HZ * 5);
      3'd1:    p = PERIOD_W'(CLK_HZ * 4);
      3'd2:    p = PERIOD_W'(CLK_HZ * 3);
      3'd3:    p = PERIOD_W'(CLK_HZ * 2);
      3'd4:    p = PERIOD_W'(CLK_HZ);
      3'd5:    p = PERIOD_W'(CLK_HZ / 2);
      3'd6:    p = PERIOD_W'(CLK_HZ / 4);
      3'd7:    p = PERIOD_W'(CLK_HZ / 10);
      default: p = PERIOD_W'(CLK_HZ / 10);
    endcase
    return p;
  endfunction

endpackage

// ----- design/drlc_if.sv -----
// Request and result channel interfaces for the running light controller.
// No dependencies.
interface drlc_req_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [3:0] key_pins;
  logic       switch_pin;

  modport source(output valid, req_type, key_pins, switch_pin, input ready);
  modport sink(input valid, req_type, key_pins, switch_pin, output ready);
endinterface

interface drlc_res_if;
  logic        valid;
  logic        ready;
  logic [3:0]  led_pattern;
  logic [2:0]  speed_level;
  logic [27:0] step_period;
  logic        restart_timer;
  logic        is_running;

  modport source(output valid, led_pattern, speed_level, step_period, restart_timer,
                 is_running, input ready);
  modport sink(input valid, led_pattern, speed_level, step_period, restart_timer,
               is_running, output ready);
endinterface

// ----- design/drlc_debounce_lane.sv -----
// One key debounce lane: hold counter, accepted level, press-edge output.
// Depends on drlc_pkg.
module drlc_debounce_lane
  import drlc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  poll,
  input  logic                  level,
  input  logic [DEBOUNCE_W-1:0] need,
  output logic                  press
);

  logic                  stable, stable_next;
  logic [DEBOUNCE_W-1:0] count, count_next, count_inc;

  always_comb begin
    count_inc = count + 1'b1;
    stable_next = stable;
    count_next = count;
    press = 1'b0;
    if (level == stable) begin
      count_next = '0;
    end else if (count_inc < need) begin
      count_next = count_inc;
    end else begin
      count_next = '0;
      stable_next = level;
      press = poll & level;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stable <= 1'b0;
      count <= '0;
    end else if (poll) begin
      stable <= stable_next;
      count <= count_next;
    end
  end

endmodule

// ----- design/drlc_merge.sv -----
// Merge stage: applies key events in key order and step events to the ring state.
// Depends on drlc_pkg.
module drlc_merge
  import drlc_pkg::*;
#(
  parameter int LED_RING_SIZE = DEF_LED_RING_SIZE,
  parameter int SPEED_STEPS = DEF_SPEED_STEPS
)(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   step,
  input  logic                   switch_pin,
  input  drlc_keys_t             keys,
  input  logic                   update,
  input  logic [DEF_SPEED_W-1:0] default_speed,
  output drlc_result_t           result
);

  localparam int PW = $clog2(LED_RING_SIZE);
  localparam int SW = $clog2(SPEED_STEPS);
  localparam logic [PW-1:0] POS_LAST = PW'(LED_RING_SIZE - 1);
  localparam logic [SW-1:0] SPEED_LAST = SW'(SPEED_STEPS - 1);
  localparam logic [SW-1:0] SPEED_RESET =
    (int'(DEFAULT_SPEED_RESET) > SPEED_STEPS - 1) ? SPEED_LAST : SW'(DEFAULT_SPEED_RESET);

  logic [PW-1:0] position, position_next;
  logic [SW-1:0] speed, speed_next, speed_mid, def_clamped;
  logic          running, running_next, restart;
  logic [SW+3:0] def_ext;
  logic [SW+2:0] spd_ext;
  logic [PW+4:0] pos_ext;

  always_comb begin
    def_ext = {{(SW+1){1'b0}}, default_speed};
    def_clamped = (def_ext > (SW+4)'(SPEED_STEPS - 1)) ? SPEED_LAST : def_ext[SW-1:0];

    position_next = position;
    running_next = running;
    restart = 1'b0;

    if (step && running) begin
      if (switch_pin) begin
        position_next = (position == POS_LAST) ? '0 : position + 1'b1;
      end else begin
        position_next = (position == '0) ? POS_LAST : position - 1'b1;
      end
    end

    speed_mid = speed;
    if (keys.faster && speed != SPEED_LAST) begin
      speed_mid = speed + 1'b1;
      restart = 1'b1;
    end
    speed_next = speed_mid;
    if (keys.slower && speed_mid != '0) begin
      speed_next = speed_mid - 1'b1;
      restart = 1'b1;
    end
    if (keys.toggle_run) begin
      running_next = ~running;
    end
    if (keys.restore) begin
      position_next = '0;
      speed_next = def_clamped;
      running_next = 1'b1;
      restart = 1'b1;
    end

    // result reflects the state after this event
    pos_ext = {5'b0, position_next};
    spd_ext = {3'b0, speed_next};
    for (int i = 0; i < 4; i++) begin
      result.led_pattern[i] = (pos_ext == (PW+5)'(i));
    end
    result.speed_level = spd_ext[2:0];
    result.step_period = period_of((spd_ext > (SW+3)'(PERIOD_TABLE_LEN - 1)) ?
                                   3'(PERIOD_TABLE_LEN - 1) : spd_ext[2:0]);
    result.restart_timer = restart;
    result.is_running = running_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position <= '0;
      speed <= SPEED_RESET;
      running <= 1'b1;
    end else if (update) begin
      position <= position_next;
      speed <= speed_next;
      running <= running_next;
    end
  end

endmodule

// ----- design/debounced_running_light_controller.sv -----
// Top level of the debounced running light controller.
// Depends on drlc_pkg, drlc_if, drlc_debounce_lane and drlc_merge.
//
// Usage:
//   req channel: one request per timer event. req_type REQ_STEP moves the
//   lit LED one place (up when switch_pin is 1, down when 0) while running;
//   REQ_POLL samples the four active-low key_pins. Each key has its own
//   debounce lane; press edges are merged in key order: faster, slower,
//   run toggle, restore defaults.
//   res channel: exactly one result per request, in order: LED pattern,
//   speed level, step period (clock cycles), timer restart flag, run state.
//   cfg port: cfg_we/cfg_index/cfg_data write the debounce hold (index 0)
//   and default_speed (index 1); write only while idle.
// Result: registered in the output register, or in the skid register during a stall.
// Throughput: one request per cycle while req.ready is high; all lanes and the merge
//   stage are combinational, the output register plus a skid stage decouple sides.
// Reset: LED at position 0, speed = default_speed (4), running, all keys
//   released with zero hold counts, config back to debounce 4, speed 4.
// Stall: with res.ready low, one more request is parked in the skid
//   register; req.ready drops only while that register is full.
module debounced_running_light_controller
  import drlc_pkg::*;
#(
  parameter int LED_RING_SIZE = DEF_LED_RING_SIZE,
  parameter int SPEED_STEPS = DEF_SPEED_STEPS
)(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  drlc_req_if.sink               req,
  drlc_res_if.source             res
);

  // configuration registers
  logic [DEBOUNCE_W-1:0]  hold_polls;
  logic [DEF_SPEED_W-1:0] default_speed;
  logic [DEBOUNCE_W-1:0]  need;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_polls <= DEBOUNCE_RESET;
      default_speed <= DEFAULT_SPEED_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HOLD_POLLS:    hold_polls <= cfg_data[DEBOUNCE_W-1:0];
        CFG_DEFAULT_SPEED: default_speed <= cfg_data[DEF_SPEED_W-1:0];
        default:           ;
      endcase
    end
  end

  // a zero debounce acts like one poll
  assign need = (hold_polls == '0) ? DEBOUNCE_W'(1) : hold_polls;

  // request handshake
  logic accept, poll, step;
  logic skid_valid, out_valid;

  assign req.ready = ~skid_valid;
  assign accept = req.valid & req.ready;
  assign poll = accept & (req.req_type == REQ_POLL);
  assign step = accept & (req.req_type == REQ_STEP);

  // debounce lanes, one per key; pins are active low
  logic [KEY_NUMBER-1:0] press;

  for (genvar k = 0; k < KEY_NUMBER; k++) begin : g_lane
    drlc_debounce_lane u_lane (
      .clk   (clk),
      .rst   (rst),
      .poll  (poll),
      .level (~req.key_pins[k]),
      .need  (need),
      .press (press[k])
    );
  end

  drlc_keys_t   keys;
  drlc_result_t result;

  assign keys.faster = press[KEY_SPEED_UP];
  assign keys.slower = press[KEY_SPEED_DOWN];
  assign keys.toggle_run = press[KEY_RUN];
  assign keys.restore = press[KEY_RESTORE];

  drlc_merge #(
    .LED_RING_SIZE (LED_RING_SIZE),
    .SPEED_STEPS   (SPEED_STEPS)
  ) u_merge (
    .clk           (clk),
    .rst           (rst),
    .step          (step),
    .switch_pin    (req.switch_pin),
    .keys          (keys),
    .update        (accept),
    .default_speed (default_speed),
    .result        (result)
  );

  // output register with skid stage
  drlc_result_t out_data, skid_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (res.ready || !out_valid) begin
      out_valid <= skid_valid | accept;
      skid_valid <= 1'b0;
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (res.ready || !out_valid) begin
      out_data <= skid_valid ? skid_data : result;
    end else if (accept) begin
      skid_data <= result;
    end
  end

  assign res.valid = out_valid;
  assign res.led_pattern = out_data.led_pattern;
  assign res.speed_level = out_data.speed_level;
  assign res.step_period = out_data.step_period;
  assign res.restart_timer = out_data.restart_timer;
  assign res.is_running = out_data.is_running;

  // a parked request always sits behind a shown one
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register full while output empty");

  // key presses only come from an accepted poll
  a_press_on_poll: assert property (@(posedge clk) disable iff (rst)
    (press != '0) |-> poll)
    else $error("key press outside a poll request");

  // step requests never restart the timer
  a_step_no_restart: assert property (@(posedge clk) disable iff (rst)
    step |-> !result.restart_timer)
    else $error("timer restart on a step request");

endmodule
